// ===== rtl/c3mc_pkg.sv =====
// Package for the 3x3 mirrored-border convolution block: sizes, register
// indexes, request codes and the pixel-triple type.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package c3mc_pkg;

  // Column store depth and pixel / coefficient formats.
  localparam int MAX_ROWS        = 1024;
  localparam int PIXEL_FRAC_BITS = 12;
  localparam int COEF_BITS       = 16;
  localparam int COEF_FRAC       = COEF_BITS - 4;
  localparam int PIX_W           = PIXEL_FRAC_BITS + 1;

  // Register field widths.
  localparam int FRAME_ROWS_W = 11;
  localparam int FRAME_COLS_W = 12;
  localparam int KERN_W       = 3 * COEF_BITS;

  // Counter widths: the row counter indexes the store, the column counter
  // runs two past the last column while the final results drain.
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int EFF_W = (FRAME_ROWS_W > ROW_W + 1) ? FRAME_ROWS_W : ROW_W + 1;
  localparam int CI_W  = FRAME_COLS_W + 1;

  // Arithmetic widths: unsigned pixel times signed coefficient, then sums.
  localparam int PROD_W   = PIX_W + 1 + COEF_BITS;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int ACC_W    = PROD_W + 4;

  // Configuration port.
  localparam int APB_DW     = 64;
  localparam int APB_AW     = 6;
  localparam int REG_LSB    = 3;
  localparam int REG_IDX_W  = APB_AW - REG_LSB;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_ROWS,
    REG_FRAME_COLS,
    REG_KERNEL_TOP,
    REG_KERNEL_MID,
    REG_KERNEL_BOTTOM
  } reg_idx_e;

  // Request codes carried in the func field.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Three horizontally adjacent pixels of one row, left in the low bits.
  typedef struct packed {
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] left;
  } triple_t;

endpackage

`default_nettype wire

// ===== rtl/c3mc_if.sv =====
// Valid/ready channel interfaces for the convolution block: the pixel
// request channel and the result channel.
// Depends on c3mc_pkg for the pixel width.
`default_nettype none

interface c3mc_pix_if;
  import c3mc_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, func, pixel_in, input ready);
  modport sink   (input valid, func, pixel_in, output ready);
endinterface

interface c3mc_res_if;
  import c3mc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;

  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/conv3x3_mirror_clamp.sv =====
// 3x3 convolution of a column-major pixel stream with edge-repeat borders,
// clamping and rounding to unsigned Q1.12.
// Depends on c3mc_pkg and the channel interfaces in c3mc_if.sv.
//
// Use: pixels of a frame arrive as requests on pix_i, column by column, with
// frame_rows pixels per column (func = pixel). Each request yields at most one
// result on res_o; the results trail the pixels by one column plus one pixel.
// Once the whole frame is in, flush requests (or further pixel requests, whose
// pixel is ignored) drain the last frame_rows + 1 results; frame_end marks the
// last one, after which the next pixel starts a new frame. A flush that
// arrives before the frame is complete is accepted and has no effect.
// Throughput is one request per clock unless res_o stalls: each request makes
// one read of the dual-column store, a write to it outside the drain and one
// shift of the window registers, and the read for the following row is issued
// in the same cycle. The result of a request that completes a window passes
// through the window, product, row-sum and clamp registers to reach res_o.
// Reset clears the counters and window, sets a 1024 x 1024 frame and a kernel
// of one on the middle-row left tap; the store is not cleared and need not be.
// When res_o stalls, the four pipeline stages fill and pix_i.ready falls in
// the cycle after the last free stage is taken; nothing is lost or repeated.
// Register writes (frame size, kernel rows) are to be made while idle; a
// write to either frame size register abandons the frame in progress.
`default_nettype none

module conv3x3_mirror_clamp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  c3mc_pix_if.sink                     pix_i,
  c3mc_res_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [c3mc_pkg::APB_AW-1:0]  paddr,
  input  logic [c3mc_pkg::APB_DW-1:0]  pwdata,
  output logic [c3mc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import c3mc_pkg::*;

  localparam logic [ACC_W-1:0] ACC_ONE  = ACC_W'(1) << (PIXEL_FRAC_BITS + COEF_FRAC);
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic [PIX_W-1:0] PIX_ONE  = PIX_W'(1) << PIXEL_FRAC_BITS;
  localparam logic [EFF_W-1:0] ROWS_MAX = EFF_W'(MAX_ROWS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [FRAME_ROWS_W-1:0] frame_rows_q;
  logic [FRAME_COLS_W-1:0] frame_cols_q;
  logic [KERN_W-1:0]       kernel_top_q, kernel_mid_q, kernel_bottom_q;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    cfg_we;
  logic                    cfg_geom;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_LSB +: REG_IDX_W];
  assign cfg_we  = psel && penable && pwrite && pready;
  // A write to either frame size register restarts the frame.
  assign cfg_geom = cfg_we && (reg_idx == REG_FRAME_ROWS || reg_idx == REG_FRAME_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q    <= FRAME_ROWS_W'(1024);
      frame_cols_q    <= FRAME_COLS_W'(1024);
      kernel_top_q    <= '0;
      kernel_mid_q    <= KERN_W'(4096);
      kernel_bottom_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_FRAME_ROWS:    frame_rows_q    <= pwdata[FRAME_ROWS_W-1:0];
        REG_FRAME_COLS:    frame_cols_q    <= pwdata[FRAME_COLS_W-1:0];
        REG_KERNEL_TOP:    kernel_top_q    <= pwdata[KERN_W-1:0];
        REG_KERNEL_MID:    kernel_mid_q    <= pwdata[KERN_W-1:0];
        REG_KERNEL_BOTTOM: kernel_bottom_q <= pwdata[KERN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_ROWS:    prdata = APB_DW'(frame_rows_q);
      REG_FRAME_COLS:    prdata = APB_DW'(frame_cols_q);
      REG_KERNEL_TOP:    prdata = APB_DW'(kernel_top_q);
      REG_KERNEL_MID:    prdata = APB_DW'(kernel_mid_q);
      REG_KERNEL_BOTTOM: prdata = APB_DW'(kernel_bottom_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage advances when the next one has room.
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || res_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pix_i.ready = en1;

  // ---------------------------------------------------------------------
  // Stage 1: counters, column store and window registers
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0]    ri_q, ri_d;
  logic [CI_W-1:0]     ci_q, ci_d;
  triple_t             w1_q, w2_q;
  triple_t             w1_d, w2_d;

  // Each store word holds the previous column's pixel (upper half) and the
  // pixel two columns back (lower half) of one row.
  logic [2*PIX_W-1:0]  store_q [MAX_ROWS];
  logic [2*PIX_W-1:0]  rd_q;
  logic [2*PIX_W-1:0]  wr_data;
  logic                mem_we;

  logic [EFF_W-1:0]        rows_eff;
  logic [FRAME_COLS_W-1:0] cols_eff;
  logic                    accept, is_flush, draining, act;
  logic [PIX_W-1:0]        st_a, st_b, px_new;
  triple_t                 col_trip, above_t, mid_t, below_t;
  logic                    row0, emit, last, ro_first;

  always_comb begin
    // Out-of-range frame sizes are folded into the supported range.
    if (frame_rows_q == '0) begin
      rows_eff = EFF_W'(1);
    end else if (EFF_W'(frame_rows_q) > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = EFF_W'(frame_rows_q);
    end
    cols_eff = (frame_cols_q == '0) ? FRAME_COLS_W'(1) : frame_cols_q;

    accept   = pix_i.valid && pix_i.ready;
    is_flush = (pix_i.func == FUNC_FLUSH);
    draining = ci_q >= CI_W'(cols_eff);
    // A flush before the frame is complete is swallowed.
    act      = accept && !(is_flush && !draining);

    st_a   = rd_q[PIX_W-1:0];
    st_b   = rd_q[2*PIX_W-1:PIX_W];
    // While draining, the last column is repeated as the right neighbour.
    px_new = draining ? st_b : pix_i.pixel_in;

    if (ci_q <= CI_W'(cols_eff)) begin
      col_trip.left   = (ci_q == CI_W'(1)) ? st_b : st_a;
      col_trip.centre = st_b;
      col_trip.right  = px_new;
    end else begin
      col_trip = '0;
    end

    // On the first row of a column the result served is the bottom row of
    // the previous column, whose lower neighbour is itself.
    row0 = (ri_q == '0);
    if (!row0) begin
      emit     = ci_q >= CI_W'(1);
      below_t  = col_trip;
      ro_first = (ri_q == ROW_W'(1));
    end else begin
      emit     = ci_q >= CI_W'(2);
      below_t  = w2_q;
      ro_first = (rows_eff == EFF_W'(1));
    end
    mid_t   = w2_q;
    above_t = ro_first ? w2_q : w1_q;
    last    = row0 && (ci_q == CI_W'(cols_eff) + CI_W'(1));

    mem_we  = act && !draining;
    wr_data = {px_new, st_b};

    ri_d = ri_q;
    ci_d = ci_q;
    w1_d = w1_q;
    w2_d = w2_q;
    if (cfg_geom) begin
      ri_d = '0;
      ci_d = '0;
    end else if (act) begin
      if (last) begin
        ri_d = '0;
        ci_d = '0;
      end else begin
        w1_d = w2_q;
        w2_d = col_trip;
        if (EFF_W'(ri_q) + EFF_W'(1) >= rows_eff) begin
          ri_d = '0;
          ci_d = ci_q + CI_W'(1);
        end else begin
          ri_d = ri_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= '0;
      ci_q <= '0;
      w1_q <= '0;
      w2_q <= '0;
    end else begin
      ri_q <= ri_d;
      ci_q <= ci_d;
      w1_q <= w1_d;
      w2_q <= w2_d;
    end
  end

  // The store is read into a register at the next row; a write to that same
  // row (single-row frames) is passed straight through.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[ri_q] <= wr_data;
    end
    if (mem_we && (ri_d == ri_q)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= store_q[ri_d];
    end
  end

  triple_t trip1_q [3];
  logic    last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= act && emit && !cfg_geom;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      trip1_q[0] <= above_t;
      trip1_q[1] <= mid_t;
      trip1_q[2] <= below_t;
      last1_q    <= last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: nine products, one per window tap
  // ---------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] px_of(triple_t t, int unsigned j);
    logic [PIX_W-1:0] p;
    case (j)
      0:       p = t.left;
      1:       p = t.centre;
      default: p = t.right;
    endcase
    return p;
  endfunction

  logic [KERN_W-1:0]         kern [3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [PROD_W-1:0]  px_ext, cf_ext;
  logic [COEF_BITS-1:0]      cf;
  logic                      last2_q;

  always_comb begin
    kern[0] = kernel_top_q;
    kern[1] = kernel_mid_q;
    kern[2] = kernel_bottom_q;
    px_ext  = '0;
    cf_ext  = '0;
    cf      = '0;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        cf     = kern[r][j*COEF_BITS +: COEF_BITS];
        px_ext = signed'({{(PROD_W-PIX_W){1'b0}}, px_of(trip1_q[r], j)});
        cf_ext = signed'({{(PROD_W-COEF_BITS){cf[COEF_BITS-1]}}, cf});
        prod_d[r][j] = px_ext * cf_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q  <= prod_d;
      last2_q <= last1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: one sum per kernel row
  // ---------------------------------------------------------------------
  logic signed [ROWSUM_W-1:0] rsum_q [3];
  logic                       last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        rsum_q[r] <= ROWSUM_W'(prod_q[r][0]) + ROWSUM_W'(prod_q[r][1])
                   + ROWSUM_W'(prod_q[r][2]);
      end
      last3_q <= last2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: total, clamp to [0, 1] and round half up into the result
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] total;
  logic [ACC_W-1:0]        rounded;
  logic [PIX_W-1:0]        px_res;
  logic [PIX_W-1:0]        pix_out_q;
  logic                    fend_q;

  always_comb begin
    total   = ACC_W'(rsum_q[0]) + ACC_W'(rsum_q[1]) + ACC_W'(rsum_q[2]);
    rounded = total + ACC_HALF;
    if (total[ACC_W-1] || total == '0) begin
      px_res = '0;
    end else if (total >= ACC_ONE) begin
      px_res = PIX_ONE;
    end else begin
      px_res = rounded[COEF_FRAC +: PIX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pix_out_q <= px_res;
      fend_q    <= last3_q;
    end
  end

  assign res_o.valid     = v4_q;
  assign res_o.pixel_out = pix_out_q;
  assign res_o.frame_end = fend_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EFF_W'(ri_q) < rows_eff)
    else $error("row counter beyond the frame height");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ci_q <= CI_W'(cols_eff) + CI_W'(1))
    else $error("column counter beyond the drain column");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && last) |=> (ri_q == '0 && ci_q == '0))
    else $error("counters not cleared after the last result of a frame");

  a_early_flush_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_flush && !draining && !cfg_we)
      |=> ($stable(ri_q) && $stable(ci_q) && !$past(mem_we)))
    else $error("early flush changed the frame state");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v4_q) |-> $past(v3_q))
    else $error("result appeared without a sum in the previous stage");

endmodule

`default_nettype wire

// ===== test/conv3x3_mirror_clamp_test.sv =====
// Self-checking testbench for conv3x3_mirror_clamp: streams column-major frames with
// random flow control, predicts each filtered pixel and compares the results in order.
// Depends on c3mc_pkg, the channel interfaces in c3mc_if.sv and the block itself.
`timescale 1ns / 1ps

module conv3x3_mirror_clamp_test;
  import c3mc_pkg::*;

  // Run-length and flow-control constants.
  localparam int RANDOM_ITEMS  = 1950;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;

  // Unity in the pixel and coefficient formats.
  localparam logic [PIX_W-1:0]     PIX_ONE  = PIX_W'(1 << PIXEL_FRAC_BITS);
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

  // Kernel styles used by the random phases.
  typedef enum int {
    KERN_IDENTITY,
    KERN_SMALL,
    KERN_RANDOM,
    KERN_EXTREME,
    KERN_BLUR
  } kern_style_e;

  // One request on the pixel channel and one filtered pixel on the result channel.
  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } conv_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  c3mc_pix_if pix_if ();
  c3mc_res_if res_if ();

  conv3x3_mirror_clamp dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, the two column stores, the
  // two most recent row triples and the input position within the frame.
  // ---------------------------------------------------------------------------
  logic [FRAME_ROWS_W-1:0] cfg_rows;
  logic [FRAME_COLS_W-1:0] cfg_cols;
  logic [KERN_W-1:0]       kern_rows [3];  // top, middle, bottom

  logic [PIX_W-1:0] col_two_back [MAX_ROWS];
  logic [PIX_W-1:0] col_prev     [MAX_ROWS];
  triple_t          win_old;
  triple_t          win_new;
  int unsigned      in_row;
  int unsigned      in_col;

  // Requests waiting for the driver, and filtered pixels waiting for the block.
  pix_req_t  req_q[$];
  conv_out_t filtered_q[$];

  int reqs_queued;
  int reqs_taken;
  int rand_items;
  int errors;

  // Flow-control state of the driver and of the result receiver.
  int burst_left;
  int gap_left;
  int rx_mode;
  int mode_left;
  int hold_left;
  int hold_req;
  int hold_seen;
  int stall_cycles;

  // Sum of the 3x3 window times the kernel, clamped to [0, 1] and rounded to
  // the pixel format with halves going up.
  function automatic logic [PIX_W-1:0] conv_pixel(input triple_t above, input triple_t centre,
                                                  input triple_t below);
    triple_t                     rows [3];
    longint                      acc;
    longint                      one;
    logic [PIX_W-1:0]            p;
    logic signed [COEF_BITS-1:0] c;
    int                          r;
    int                          j;
    rows[0] = above;
    rows[1] = centre;
    rows[2] = below;
    acc = 0;
    one = longint'(1) << (PIXEL_FRAC_BITS + COEF_FRAC);
    for (r = 0; r < 3; r++) begin
      for (j = 0; j < 3; j++) begin
        p = rows[r][j*PIX_W +: PIX_W];
        c = kern_rows[r][j*COEF_BITS +: COEF_BITS];
        acc += longint'(p) * longint'(c);
      end
    end
    if (acc <= 0) return '0;
    if (acc >= one) return PIX_ONE;
    return PIX_W'((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC);
  endfunction

  // Advances the predicted block by one accepted request. Returns 1 when the
  // request causes a filtered pixel, which is then given in res.
  function automatic bit conv_step(input logic func, input logic [PIX_W-1:0] pix,
                                   output conv_out_t res);
    int unsigned      nrows;
    int unsigned      ncols;
    int unsigned      ri;
    int unsigned      ci;
    int unsigned      idx;
    int unsigned      ro;
    int unsigned      co;
    int unsigned      oc;
    bit               draining;
    bit               emit;
    bit               last;
    triple_t          trip;
    triple_t          above;
    triple_t          mid;
    triple_t          below;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] n;
    nrows = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
    ncols = (cfg_cols == 0) ? 1 : cfg_cols;
    ri = in_row % nrows;
    ci = in_col;
    idx = ri % MAX_ROWS;
    draining = ci >= ncols;
    trip = '0;
    emit = 1'b0;
    last = 1'b0;
    res = '0;
    // A flush before the frame is complete changes nothing.
    if (func == FUNC_FLUSH && !draining) return 1'b0;
    if (ci <= ncols) begin
      a = col_two_back[idx];
      b = col_prev[idx];
      // While draining the pixel is ignored and the right edge is repeated.
      n = draining ? b : pix;
      oc = ci - 1;
      trip.left   = (ci == 1) ? b : a;
      trip.centre = b;
      trip.right  = (ci >= 1 && oc == ncols - 1) ? b : n;
      if (!draining) begin
        col_two_back[idx] = b;
        col_prev[idx]     = n;
      end
    end
    if (ri >= 1) begin
      emit  = ci >= 1;
      ro    = ri - 1;
      co    = ci - 1;
      mid   = win_new;
      below = trip;
    end else begin
      // The bottom row of a column repeats itself as its lower neighbour.
      emit  = ci >= 2;
      ro    = nrows - 1;
      co    = ci - 2;
      mid   = win_new;
      below = win_new;
    end
    above = (ro == 0) ? mid : win_old;
    if (emit) begin
      res.pixel     = conv_pixel(above, mid, below);
      last          = (ro == nrows - 1) && (co == ncols - 1);
      res.frame_end = last;
    end
    if (last) begin
      in_row = 0;
      in_col = 0;
      return 1'b1;
    end
    win_old = win_new;
    win_new = trip;
    ri++;
    if (ri >= nrows) begin
      ri = 0;
      ci++;
    end
    in_row = ri;
    in_col = ci;
    return emit;
  endfunction

  function automatic logic [KERN_W-1:0] kern3(input logic [COEF_BITS-1:0] c_left,
                                              input logic [COEF_BITS-1:0] c_centre,
                                              input logic [COEF_BITS-1:0] c_right);
    return {c_right, c_centre, c_left};
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef(input kern_style_e style, input int j);
    case (style)
      KERN_IDENTITY: return (j == 1) ? COEF_ONE >> $urandom_range(0, 2) : '0;
      KERN_SMALL:    return COEF_BITS'($urandom_range(0, 2048)) - COEF_BITS'(1024);
      KERN_RANDOM:   return COEF_BITS'($urandom);
      KERN_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'hFFFF;
          3:       return 16'h0001;
          default: return '0;
        endcase
      end
      default:       return COEF_BITS'(455);  // about one ninth
    endcase
  endfunction

  function automatic logic [KERN_W-1:0] rand_kernel(input kern_style_e style);
    logic [KERN_W-1:0] k;
    int                j;
    for (j = 0; j < 3; j++) k[j*COEF_BITS +: COEF_BITS] = rand_coef(style, j);
    return k;
  endfunction

  // Mostly in-range pixels, with zero, one and the full 13-bit range mixed in.
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIX_ONE;
      2:       return PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
      default: return PIX_W'($urandom_range(0, PIX_ONE));
    endcase
  endfunction

  task automatic push_req(input logic func, input logic [PIX_W-1:0] pix);
    pix_req_t req;
    req.func  = func;
    req.pixel = pix;
    req_q.push_back(req);
    reqs_queued++;
  endtask

  // Queues npix pixels of a frame of nrows x ncols (effective sizes), with the
  // odd early flush as noise. A complete frame is followed by its drain, in
  // which some requests are pixels that the block must treat as flushes.
  task automatic queue_frame(input int nrows, input int ncols, input int npix,
                             input bit counted);
    int k;
    for (k = 0; k < npix; k++) begin
      if ($urandom_range(0, 29) == 0) push_req(FUNC_FLUSH, rand_pixel());
      push_req(FUNC_PIXEL, rand_pixel());
      if (counted) rand_items++;
    end
    if (npix == nrows * ncols) begin
      for (k = 0; k <= nrows; k++) begin
        push_req(($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_FLUSH, rand_pixel());
        if (counted) rand_items++;
      end
    end
  endtask

  // Waits until every request is taken and every filtered pixel has arrived,
  // then gives the pipeline time to finish requests that cause no result.
  task automatic wait_idle();
    while (reqs_taken != reqs_queued || filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write through the configuration port, followed by a read-back.
  // The predictor takes the new value at the same point as the block.
  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] mask;
    logic [APB_DW-1:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FRAME_ROWS: begin
        mask     = (64'd1 << FRAME_ROWS_W) - 1;
        cfg_rows = value[FRAME_ROWS_W-1:0];
        in_row   = 0;
        in_col   = 0;
      end
      REG_FRAME_COLS: begin
        mask     = (64'd1 << FRAME_COLS_W) - 1;
        cfg_cols = value[FRAME_COLS_W-1:0];
        in_row   = 0;
        in_col   = 0;
      end
      REG_KERNEL_TOP: begin
        mask         = (64'd1 << KERN_W) - 1;
        kern_rows[0] = value[KERN_W-1:0];
      end
      REG_KERNEL_MID: begin
        mask         = (64'd1 << KERN_W) - 1;
        kern_rows[1] = value[KERN_W-1:0];
      end
      default: begin
        mask         = (64'd1 << KERN_W) - 1;
        kern_rows[2] = value[KERN_W-1:0];
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    readback = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== (value & mask)) begin
      $display("%0t: register %s read-back mismatch, expected %0h actual %0h",
               $time, idx.name(), value & mask, readback);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends queued requests in bursts of random length, with random gaps
  // between bursts and bursts without any gap. A request stays on the channel
  // until it is taken; valid is only touched when the slot has just emptied.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    pix_req_t nxt;
    if (!rst_ni) begin
      pix_if.valid    <= 1'b0;
      pix_if.func     <= FUNC_PIXEL;
      pix_if.pixel_in <= '0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        pix_if.valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        pix_if.valid    <= 1'b1;
        pix_if.func     <= nxt.func;
        pix_if.pixel_in <= nxt.pixel;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: switches between always ready, even odds, mostly ready and
  // mostly stalled. A hold-off request from the stimulus makes it refuse
  // results for a long stretch, so that the pipeline fills and the block has
  // to stall its pixel channel while the driver keeps offering requests.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_mode      <= 0;
      mode_left    <= 0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= $urandom_range(0, 1);
        2:       res_if.ready <= $urandom_range(0, 9) != 0;
        default: res_if.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted request goes through the predictor; every accepted
  // result is compared with the oldest filtered pixel still outstanding.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    conv_out_t want;
    conv_out_t got;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        if (conv_step(pix_if.func, pix_if.pixel_in, want)) filtered_q.push_back(want);
        reqs_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        got.pixel     = res_if.pixel_out;
        got.frame_end = res_if.frame_end;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual pixel_out %0d frame_end %0b",
                   $time, got.pixel, got.frame_end);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                     $time, want.pixel, got.pixel);
            errors++;
          end
          if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end mismatch, expected %0b actual %0b",
                     $time, want.frame_end, got.frame_end);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which no request, result or register
  // access completes means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                 (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a short directed part, then random phases. Each phase starts with
  // the block idle, rewrites the frame size (abandoning any partial frame) and
  // some kernel rows, then queues one to three frames for the driver.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          phase;
    int          nframes;
    int          f;
    int          nr;
    int          nc;
    int          rows_eff;
    int          cols_eff;
    int          npix;
    int          k;
    kern_style_e style;

    // Every input starts at a known value, with reset asserted.
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_if.valid    = 1'b0;
    pix_if.func     = FUNC_PIXEL;
    pix_if.pixel_in = '0;
    res_if.ready    = 1'b0;
    hold_req        = 0;
    reqs_queued     = 0;
    reqs_taken      = 0;
    rand_items      = 0;
    errors          = 0;

    // Predictor after reset: 1024 x 1024 frame and one on the middle-row left tap.
    cfg_rows     = FRAME_ROWS_W'(1024);
    cfg_cols     = FRAME_COLS_W'(1024);
    kern_rows[0] = '0;
    kern_rows[1] = KERN_W'(4096);
    kern_rows[2] = '0;
    for (k = 0; k < MAX_ROWS; k++) begin
      col_two_back[k] = '0;
      col_prev[k]     = '0;
    end
    win_old = '0;
    win_new = '0;
    in_row  = 0;
    in_col  = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 3x3 frame with distinct weights on every neighbour, so that
    // each mirrored border shows. It opens with an early flush, carries zero,
    // one and out-of-range pixels, and its drain includes a pixel request.
    write_reg(REG_FRAME_ROWS, 3);
    write_reg(REG_FRAME_COLS, 3);
    write_reg(REG_KERNEL_TOP, kern3(16'h0100, 16'h0200, 16'h0300));
    write_reg(REG_KERNEL_MID, kern3(16'h0080, 16'h0800, 16'h0180));
    write_reg(REG_KERNEL_BOTTOM, kern3(16'h0040, 16'h0400, 16'h00C0));
    push_req(FUNC_FLUSH, 13'd1234);
    push_req(FUNC_PIXEL, '0);
    push_req(FUNC_PIXEL, PIX_ONE);
    push_req(FUNC_PIXEL, 13'd8191);
    push_req(FUNC_PIXEL, 13'd1);
    push_req(FUNC_PIXEL, 13'd2048);
    push_req(FUNC_PIXEL, 13'd4095);
    push_req(FUNC_PIXEL, PIX_ONE);
    push_req(FUNC_PIXEL, '0);
    push_req(FUNC_PIXEL, 13'd8191);
    push_req(FUNC_FLUSH, '0);
    push_req(FUNC_PIXEL, 13'd8191);
    push_req(FUNC_FLUSH, '0);
    push_req(FUNC_FLUSH, '0);
    wait_idle();

    // Directed: zero sizes act as a single pixel. A half coefficient on the
    // centre gives exact halves, which must round up.
    write_reg(REG_FRAME_ROWS, 0);
    write_reg(REG_FRAME_COLS, 0);
    write_reg(REG_KERNEL_TOP, '0);
    write_reg(REG_KERNEL_MID, kern3('0, COEF_ONE >> 1, '0));
    write_reg(REG_KERNEL_BOTTOM, '0);
    push_req(FUNC_PIXEL, 13'd4095);
    push_req(FUNC_FLUSH, '0);
    push_req(FUNC_FLUSH, '0);
    push_req(FUNC_PIXEL, 13'd8191);
    push_req(FUNC_FLUSH, '0);
    push_req(FUNC_PIXEL, 13'd3);

    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 2) begin
        // Tallest frame: a row count above the store depth acts as the depth.
        // The first column and the start of the second are sent, so that the
        // row counter wraps at the depth; the next geometry write abandons
        // the rest.
        write_reg(REG_FRAME_ROWS, (1 << FRAME_ROWS_W) - 1);
        write_reg(REG_FRAME_COLS, 2);
        write_reg(REG_KERNEL_MID, rand_kernel(KERN_SMALL));
        queue_frame(MAX_ROWS, 2, MAX_ROWS + 64, 1'b1);
      end else if (phase == 5) begin
        // Widest frame, one row high: only a part of it is sent and the next
        // geometry write abandons the rest.
        write_reg(REG_FRAME_ROWS, 1);
        write_reg(REG_FRAME_COLS, (1 << FRAME_COLS_W) - 1);
        write_reg(REG_KERNEL_TOP, rand_kernel(KERN_BLUR));
        queue_frame(1, (1 << FRAME_COLS_W) - 1, 300, 1'b1);
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            nr = 0;
            nc = $urandom_range(1, 6);
          end
          1: begin
            nr = $urandom_range(1, 8);
            nc = 0;
          end
          2, 3: begin
            nr = $urandom_range(9, 40);
            nc = $urandom_range(1, 4);
          end
          default: begin
            nr = $urandom_range(1, 8);
            nc = $urandom_range(1, 6);
          end
        endcase
        // The second random phase is the one that fills the block under a hold.
        if (phase == 1) begin
          nr = 6;
          nc = 5;
        end
        write_reg(REG_FRAME_ROWS, nr);
        write_reg(REG_FRAME_COLS, nc);
        if (phase == 0) begin
          // Kernel register extremes: all ones above, all zeros below.
          write_reg(REG_KERNEL_TOP, {KERN_W{1'b1}});
          write_reg(REG_KERNEL_MID, kern3('0, COEF_ONE, '0));
          write_reg(REG_KERNEL_BOTTOM, '0);
        end else begin
          style = kern_style_e'($urandom_range(0, 4));
          if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_TOP, rand_kernel(style));
          if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_MID, rand_kernel(style));
          if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_BOTTOM, rand_kernel(style));
        end
        rows_eff = (nr == 0) ? 1 : nr;
        cols_eff = (nc == 0) ? 1 : nc;
        nframes  = $urandom_range(1, 3);
        for (f = 0; f < nframes; f++) begin
          npix = rows_eff * cols_eff;
          // Now and then the last frame of a phase is cut short.
          if (f == nframes - 1 && $urandom_range(0, 5) == 0)
            npix = $urandom_range(0, npix - 1);
          queue_frame(rows_eff, cols_eff, npix, 1'b1);
          if ($urandom_range(0, 4) == 0) push_req(FUNC_FLUSH, rand_pixel());
        end
      end
      if (phase == 1 || $urandom_range(0, 5) == 0) begin
        @(posedge clk_i);
        hold_req <= hold_req + 1;
      end
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/c3mc_pkg.sv
rtl/c3mc_if.sv
rtl/conv3x3_mirror_clamp.sv
test/conv3x3_mirror_clamp_test.sv
